>>> design/assert_macros.svh
// Assertion macros included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RBSF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RBSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rbsf_pkg.sv
// Shared constants and types of the ROM bank slot cache directory.
package rbsf_pkg;

   localparam int MAX_BANKS = 512;
   localparam int MAX_SLOTS = 512;

   localparam int BANK_W = $clog2(MAX_BANKS);
   localparam int RING_W = $clog2(MAX_SLOTS);
   localparam int SLOT_W = 9;
   localparam int DIR_W  = 10;
   localparam int CFG_W  = 10;
   localparam int N_W    = $clog2(((MAX_BANKS > MAX_SLOTS) ? MAX_BANKS : MAX_SLOTS) + 1);

   localparam logic [DIR_W-1:0] NOT_RESIDENT = {DIR_W{1'b1}};

   // request kinds
   localparam logic [1:0] KIND_ACCESS = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_REINIT = 2'd2;

   // register indexes
   localparam logic CSR_BANK_COUNT = 1'b0;
   localparam logic CSR_RESIDENT   = 1'b1;

   localparam logic [CFG_W-1:0] BANK_COUNT_RESET = CFG_W'(2);
   localparam logic [CFG_W-1:0] RESIDENT_RESET   = CFG_W'(2);

   typedef struct packed {
      logic [BANK_W-1:0] bank_mask;   // effective bank count minus one
      logic [N_W-1:0]    resident_n;  // banks placed by reinitialize
   } cfg_type;

endpackage

>>> design/rbsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbsf_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[waddr] <= wdata;
      end
      rdata_ff <= ram_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/rbsf_csr.sv
// Configuration registers and derived bank mask / resident count.
module rbsf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [rbsf_pkg::CFG_W-1:0]  csr_wdata,
   output rbsf_pkg::cfg_type           cfg
);
   import rbsf_pkg::*;

   logic [CFG_W-1:0] bank_count_ff;
   logic [CFG_W-1:0] resident_ff;
   logic [CFG_W-1:0] eff_count;
   logic [CFG_W-1:0] eff_slots;
   logic [CFG_W-1:0] eff_n;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff <= BANK_COUNT_RESET;
         resident_ff   <= RESIDENT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BANK_COUNT: bank_count_ff <= csr_wdata;
            CSR_RESIDENT:   resident_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_count = bank_count_ff;
      if (eff_count == '0) eff_count = CFG_W'(1);
      if (eff_count > CFG_W'(MAX_BANKS)) eff_count = CFG_W'(MAX_BANKS);
      eff_slots = resident_ff;
      if (eff_slots == '0) eff_slots = CFG_W'(1);
      if (eff_slots > CFG_W'(MAX_SLOTS)) eff_slots = CFG_W'(MAX_SLOTS);
      eff_n = (eff_count < eff_slots) ? eff_count : eff_slots;
   end

   // clamped values fit BANK_W / N_W bits
   assign cfg.bank_mask  = BANK_W'(eff_count - CFG_W'(1));
   assign cfg.resident_n = N_W'(eff_n);

endmodule

>>> design/rom_bank_slot_fifo_cache_unit.sv
// Top level of the ROM bank slot cache directory with FIFO replacement.
//
// Usage
//   Request channel: a request (req_kind, req_bank) is taken at a rising
//   edge with start high and busy low. Kind 0 is an access, 1 a residency
//   query, 2 a reinitialize; kind 3 is ignored and answers all zeros.
//   Result channel: one result per request, shown for a single cycle with
//   rsp_strobe high. The receiver cannot stall; results are never held.
//   Config channel: csr_valid/csr_ready with csr_index and csr_wdata;
//   csr_ready is always high. Write it only while busy is low.
//
// Timing
//   One request at a time; busy falls in the cycle the result shows.
//   Query, hit and ignored kind answer from LOOKUP; an access miss goes
//   on to VICTIM and WRITE: the directory RAM has one write port and a
//   miss needs two directory writes plus the victim's slot read. A
//   reinitialize sweep writes one directory entry per cycle over 512 banks.
//
// Reset: synchronous, active high. Clears the FSM and ring pointers and sets
//   both config registers to 2. RAM contents are undefined until the first
//   reinitialize, which must precede any access or query.
module rom_bank_slot_fifo_cache_unit (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [rbsf_pkg::BANK_W-1:0]  req_bank,
   // result channel
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic [rbsf_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                         rsp_fill_needed,
   output logic [rbsf_pkg::BANK_W-1:0]  rsp_evicted_bank,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [rbsf_pkg::CFG_W-1:0]   csr_wdata
);
   import rbsf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,   // directory entry of the request bank and ring tail are out
      ST_VICTIM,   // victim slot is out; drop victim, queue new bank
      ST_WRITE,    // give slot to new bank, answer
      ST_SWEEP     // reinitialize sweep
   } state_type;

   cfg_type cfg;

   state_type           state_ff;
   logic                rsp_strobe_ff;
   logic                rsp_hit_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_fill_ff;
   logic [BANK_W-1:0]   rsp_evicted_ff;
   logic [RING_W-1:0]   head_ff;
   logic [RING_W-1:0]   tail_ff;
   logic [N_W-1:0]      sweep_ff;
   logic [1:0]          kind_ff;
   logic [BANK_W-1:0]   bank_ff;
   logic [BANK_W-1:0]   victim_ff;
   logic [DIR_W-1:0]    slot_ff;

   // directory RAM: slot of each bank
   logic                dir_we;
   logic [BANK_W-1:0]   dir_waddr;
   logic [DIR_W-1:0]    dir_wdata;
   logic [BANK_W-1:0]   dir_raddr;
   logic [DIR_W-1:0]    dir_rdata;

   // eviction ring RAM
   logic                ring_we;
   logic [RING_W-1:0]   ring_waddr;
   logic [BANK_W-1:0]   ring_wdata;
   logic [BANK_W-1:0]   ring_rdata;

   logic                accept;
   logic [BANK_W-1:0]   masked_bank;
   logic                sweep_last;
   logic [N_W-1:0]      sweep_ring_val;
   logic                sweep_ring_we;

   rbsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rbsf_ram #(.DEPTH(MAX_BANKS), .WIDTH(DIR_W)) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (dir_wdata),
      .raddr (dir_raddr),
      .rdata (dir_rdata)
   );

   rbsf_ram #(.DEPTH(MAX_SLOTS), .WIDTH(BANK_W)) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (tail_ff),
      .rdata (ring_rdata)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign masked_bank = req_bank & cfg.bank_mask;
   assign sweep_last  = (sweep_ff == N_W'(MAX_BANKS - 1));

   // ring gets banks n-1 .. 1, oldest at position 0
   assign sweep_ring_we  = ((N_W + 1)'(sweep_ff) + (N_W + 1)'(1)) < (N_W + 1)'(cfg.resident_n);
   assign sweep_ring_val = cfg.resident_n - N_W'(1) - sweep_ff;

   // Memory port control. The FSM runs one request at a time, so a directory
   // write never overlaps a used read of the same entry: no forwarding needed.
   always_comb begin
      dir_raddr  = (state_ff == ST_IDLE) ? masked_bank : ring_rdata;
      dir_we     = 1'b0;
      dir_waddr  = bank_ff;
      dir_wdata  = slot_ff;
      ring_we    = 1'b0;
      ring_waddr = head_ff;
      ring_wdata = bank_ff;
      unique case (state_ff)
         ST_VICTIM: begin
            dir_we    = 1'b1;
            dir_waddr = victim_ff;
            dir_wdata = NOT_RESIDENT;
            ring_we   = 1'b1;
         end
         ST_WRITE: begin
            dir_we = 1'b1;
         end
         ST_SWEEP: begin
            dir_we     = 1'b1;
            dir_waddr  = sweep_ff[BANK_W-1:0];
            dir_wdata  = (sweep_ff < cfg.resident_n) ? DIR_W'(sweep_ff) : NOT_RESIDENT;
            ring_we    = sweep_ring_we;
            ring_waddr = sweep_ff[RING_W-1:0];
            ring_wdata = sweep_ring_val[BANK_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         sweep_ff      <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  kind_ff  <= req_kind;
                  bank_ff  <= masked_bank;
                  sweep_ff <= '0;
                  state_ff <= (req_kind == KIND_REINIT) ? ST_SWEEP : ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               victim_ff      <= ring_rdata;
               rsp_hit_ff     <= 1'b0;
               rsp_slot_ff    <= '0;
               rsp_fill_ff    <= 1'b0;
               rsp_evicted_ff <= '0;
               if (kind_ff == KIND_ACCESS || kind_ff == KIND_QUERY) begin
                  if (dir_rdata != NOT_RESIDENT) begin
                     rsp_hit_ff    <= 1'b1;
                     rsp_slot_ff   <= dir_rdata[SLOT_W-1:0];
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end else if (kind_ff == KIND_ACCESS && head_ff != tail_ff) begin
                     // miss: victim's slot is read next
                     state_ff <= ST_VICTIM;
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  // unused kind
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_VICTIM: begin
               slot_ff  <= dir_rdata;
               tail_ff  <= (tail_ff == RING_W'(MAX_SLOTS - 1)) ? '0 : tail_ff + RING_W'(1);
               head_ff  <= (head_ff == RING_W'(MAX_SLOTS - 1)) ? '0 : head_ff + RING_W'(1);
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               rsp_hit_ff     <= 1'b0;
               rsp_slot_ff    <= slot_ff[SLOT_W-1:0];
               rsp_fill_ff    <= 1'b1;
               rsp_evicted_ff <= victim_ff;
               rsp_strobe_ff  <= 1'b1;
               state_ff       <= ST_IDLE;
            end
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + N_W'(1);
               if (sweep_last) begin
                  tail_ff        <= '0;
                  head_ff        <= RING_W'(cfg.resident_n - N_W'(1));
                  rsp_hit_ff     <= 1'b0;
                  rsp_slot_ff    <= '0;
                  rsp_fill_ff    <= 1'b0;
                  rsp_evicted_ff <= '0;
                  rsp_strobe_ff  <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_fill_needed  = rsp_fill_ff;
   assign rsp_evicted_bank = rsp_evicted_ff;

`include "assert_macros.svh"

   `RBSF_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted request did not raise busy")
   `RBSF_ASSERT_NEXT(a_single_result, clock, reset, rsp_strobe, !rsp_strobe, "results on back-to-back cycles")
   `RBSF_ASSERT_SAME(a_hit_no_fill, clock, reset, rsp_strobe, !(rsp_hit && rsp_fill_needed), "hit and fill together")
   `RBSF_ASSERT_SAME(a_write_busy, clock, reset, dir_we || ring_we, busy, "memory written while idle")

endmodule

>>> dv/tb_rom_bank_slot_fifo_cache_unit.sv
// Self-checking testbench of the ROM bank slot cache directory, with its scoreboard.
`timescale 1ns / 100ps

import rbsf_pkg::*;

typedef struct packed {
   logic              hit;
   logic [SLOT_W-1:0] slot;
   logic              fill_needed;
   logic [BANK_W-1:0] evicted_bank;
} dir_result_type;

// Tracks the directory and FIFO ring and holds the results still owed.
class slot_directory_model;
   logic [CFG_W-1:0]  bank_count_reg;
   logic [CFG_W-1:0]  resident_reg;
   logic [DIR_W-1:0]  slot_of_bank [MAX_BANKS];
   logic [RING_W-1:0] victim_ring [MAX_SLOTS];
   logic [RING_W-1:0] ring_wr;
   logic [RING_W-1:0] ring_rd;
   dir_result_type    owed_results [$];
   int                failures;
   int                requests;
   int                ignored;
   int                fills;
   int                reinits;

   function new();
      bank_count_reg = BANK_COUNT_RESET;
      resident_reg   = RESIDENT_RESET;
      ring_wr        = '0;
      ring_rd        = '0;
      failures       = 0;
      requests       = 0;
      ignored        = 0;
      fills          = 0;
      reinits        = 0;
   endfunction

   function void write_reg(input logic idx, input logic [CFG_W-1:0] value);
      if (idx == CSR_BANK_COUNT) bank_count_reg = value;
      else resident_reg = value;
   endfunction

   function int outstanding();
      return owed_results.size();
   endfunction

   // Works out the result of one accepted request and updates the tables.
   function void note_request(input logic [1:0] kind, input logic [BANK_W-1:0] bank);
      dir_result_type    r;
      int unsigned       span;
      int unsigned       limit_n;
      int unsigned       n;
      logic [BANK_W-1:0] b;
      logic [BANK_W-1:0] victim;
      logic [DIR_W-1:0]  entry;
      int                i;
      r = '0;
      span = (bank_count_reg == 0) ? 1 : bank_count_reg;
      if (span > MAX_BANKS) span = MAX_BANKS;
      b = bank & BANK_W'(span - 1);
      requests++;
      case (kind)
         KIND_REINIT: begin
            reinits++;
            limit_n = resident_reg;
            if (limit_n < 1) limit_n = 1;
            if (limit_n > MAX_SLOTS) limit_n = MAX_SLOTS;
            n = (span < limit_n) ? span : limit_n;
            for (i = 0; i < MAX_BANKS; i++) slot_of_bank[i] = NOT_RESIDENT;
            for (i = 0; i < n; i++) slot_of_bank[i] = DIR_W'(i);
            // oldest entry first: n-1 down to 1, bank 0 stays pinned
            for (i = 0; i + 1 < n; i++) victim_ring[i] = RING_W'(n - 1 - i);
            ring_rd = '0;
            ring_wr = RING_W'((n - 1) % MAX_SLOTS);
         end
         KIND_ACCESS, KIND_QUERY: begin
            entry = slot_of_bank[b];
            if (entry != NOT_RESIDENT) begin
               r.hit  = 1'b1;
               r.slot = entry[SLOT_W-1:0];
            end else if (kind == KIND_ACCESS && ring_wr != ring_rd) begin
               victim = victim_ring[ring_rd];
               entry  = slot_of_bank[victim];
               ring_rd++;
               slot_of_bank[victim] = NOT_RESIDENT;
               slot_of_bank[b]      = entry;
               victim_ring[ring_wr] = b;
               ring_wr++;
               r.slot         = entry[SLOT_W-1:0];
               r.fill_needed  = 1'b1;
               r.evicted_bank = victim;
               fills++;
            end
         end
         default: ignored++;
      endcase
      owed_results = {owed_results, r};
   endfunction

   function void check_result(input logic hit, input logic [SLOT_W-1:0] slot,
                              input logic fill_needed, input logic [BANK_W-1:0] evicted_bank);
      dir_result_type e;
      if (owed_results.size() == 0) begin
         $error("result with no request pending: hit %0d slot %0d fill %0d evicted %0d",
                hit, slot, fill_needed, evicted_bank);
         failures++;
         return;
      end
      e = owed_results.pop_front();
      if (hit !== e.hit) begin
         $error("hit: expected %0d, actual %0d", e.hit, hit);
         failures++;
      end
      if (slot !== e.slot) begin
         $error("slot: expected %0d, actual %0d", e.slot, slot);
         failures++;
      end
      if (fill_needed !== e.fill_needed) begin
         $error("fill_needed: expected %0d, actual %0d", e.fill_needed, fill_needed);
         failures++;
      end
      if (evicted_bank !== e.evicted_bank) begin
         $error("evicted_bank: expected %0d, actual %0d", e.evicted_bank, evicted_bank);
         failures++;
      end
   endfunction
endclass

module tb_rom_bank_slot_fifo_cache_unit;

   // Reinitialize sweeps 512 entries.
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 550;

   // kind code the block ignores
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_kind = '0;
   logic [BANK_W-1:0] req_bank = '0;
   logic              rsp_strobe;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_fill_needed;
   logic [BANK_W-1:0] rsp_evicted_bank;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_BANK_COUNT;
   logic [CFG_W-1:0]  csr_wdata = '0;

   slot_directory_model dir_model = new();
   int                  cycle_count = 0;
   int                  counted_items = 0;
   int                  settings_used = 0;

   rom_bank_slot_fifo_cache_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_bank         (req_bank),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_slot         (rsp_slot),
      .rsp_fill_needed  (rsp_fill_needed),
      .rsp_evicted_bank (rsp_evicted_bank),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: a hang or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Results are one-cycle strobes; sampled at the edge that ends the cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         dir_model.check_result(rsp_hit, rsp_slot, rsp_fill_needed, rsp_evicted_bank);
   end

   // Present one request and hold it until the block takes it.
   // Called at a rising edge; returns at the accepting edge.
   task automatic send_request(input logic [1:0] kind, input logic [BANK_W-1:0] bank);
      start    <= 1'b1;
      req_kind <= kind;
      req_bank <= bank;
      do @(posedge clock); while (busy);
      dir_model.note_request(kind, bank);
      counted_items++;
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending until every owed result has come and the block is idle.
   // Checked on the falling edge so the strobe check has settled.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (dir_model.outstanding() != 0 || busy);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      dir_model.write_reg(idx, value);
   endtask

   // Both registers, written only with the directory idle.
   task automatic set_config(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] slots);
      drain();
      write_csr(CSR_BANK_COUNT, count);
      write_csr(CSR_RESIDENT, slots);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Random bursts. narrow_pct of banks come from [lo, hi] to steer hit rate.
   task automatic run_phase(input int len, input int lo, input int hi, input int narrow_pct);
      int          burst_left;
      int          k;
      int          roll;
      logic [1:0]  kind;
      logic [8:0]  bank;
      burst_left = 0;
      for (k = 0; k < len && counted_items < RANDOM_ITEMS + 30; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            // some bursts run back to back, others sit after a gap
            if ($urandom_range(0, 9) >= 3) idle_cycles($urandom_range(1, 6));
         end
         burst_left--;
         if ($urandom_range(0, 49) == 0) drain();
         roll = $urandom_range(0, 99);
         if (roll < 62)      kind = KIND_ACCESS;
         else if (roll < 88) kind = KIND_QUERY;
         else if (roll < 96) kind = KIND_UNUSED;
         else                kind = KIND_REINIT;
         if ($urandom_range(0, 99) < narrow_pct) bank = 9'($urandom_range(lo, hi));
         else bank = 9'($urandom_range(0, MAX_BANKS - 1));
         send_request(kind, bank);
      end
   endtask

   initial begin : stimulus
      int          p;
      logic [9:0]  count;
      logic [9:0]  slots;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: 8 banks in 4 slots, ring holds 3,2,1 ---
      set_config(10'd8, 10'd4);
      send_request(KIND_REINIT, 9'd0);
      send_request(KIND_ACCESS, 9'd0);     // pinned bank hit
      send_request(KIND_ACCESS, 9'd3);
      send_request(KIND_QUERY,  9'd2);
      send_request(KIND_QUERY,  9'd5);     // query miss answers zeros
      send_request(KIND_ACCESS, 9'd5);     // miss, evicts bank 3
      send_request(KIND_ACCESS, 9'd13);    // wraps to bank 5, hit
      send_request(KIND_ACCESS, 9'd7);     // miss, evicts bank 2
      send_request(KIND_QUERY,  9'd3);
      send_request(KIND_UNUSED, 9'd511);   // unused kind
      send_request(KIND_ACCESS, 9'd511);   // masks to 7
      // oversize bank count, one slot: miss finds the ring empty
      set_config(10'd1023, 10'd1);
      send_request(KIND_REINIT, 9'd0);
      send_request(KIND_ACCESS, 9'd511);
      send_request(KIND_QUERY,  9'd0);
      // zero count and zero slots clamp to one
      set_config(10'd0, 10'd0);
      send_request(KIND_REINIT, 9'd0);
      send_request(KIND_ACCESS, 9'd300);
      // count that is not a power of two, oversize slots
      set_config(10'd6, 10'd1023);
      send_request(KIND_REINIT, 9'd0);
      send_request(KIND_ACCESS, 9'd7);
      send_request(KIND_QUERY,  9'd2);
      // widen the mask without reinitialize: tables are kept
      set_config(10'd512, 10'd1023);
      send_request(KIND_ACCESS, 9'd200);
      send_request(KIND_QUERY,  9'd5);
      set_config(10'd2, 10'd512);
      send_request(KIND_REINIT, 9'd0);
      send_request(KIND_ACCESS, 9'd1);
      send_request(KIND_ACCESS, 9'd0);

      // --- random ---
      counted_items = 0;
      // nearly full directory, misses steered so the ring pointers wrap
      set_config(10'd1023, 10'd500);
      send_request(KIND_REINIT, 9'd0);
      run_phase(70, 480, 511, 100);
      p = 0;
      while (counted_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       count = 10'($urandom_range(0, 1));
            1:       count = 10'd1023;
            2:       count = 10'd512;
            3:       count = 10'(1 << $urandom_range(1, 9));
            4:       count = 10'($urandom_range(0, 1023));
            default: count = 10'd16;
         endcase
         case ($urandom_range(0, 5))
            0:       slots = 10'd0;
            1:       slots = 10'd1023;
            2:       slots = 10'd512;
            3:       slots = 10'($urandom_range(2, 40));
            4:       slots = 10'($urandom_range(0, 1023));
            default: slots = 10'd2;
         endcase
         set_config(count, slots);
         send_request(KIND_REINIT, 9'($urandom_range(0, 511)));
         run_phase($urandom_range(20, 80), 0, 15, 50);
         p++;
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests (%0d unused kinds), %0d fills, %0d reinitializations,",
               dir_model.requests, dir_model.ignored, dir_model.fills, dir_model.reinits);
      $display("over %0d register settings and %0d random phases.", settings_used, p + 1);
      if (dir_model.failures == 0 && dir_model.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
